### rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window sender package
// Shared constants and types for the sender front end, queue and engine.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int MAX_PAYLOAD_DEF = 1024;
	localparam int TIMEOUT_W = 27;
	localparam logic [26:0] TIMEOUT_RST = 27'd2000;
	localparam logic [31:0] WINDOW_END_RST = 32'h0000_ffff;
	localparam logic [23:0] AGE_MAX = 24'hff_ffff;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] byte_count;
		logic [31:0] ack_sequence;
		logic [15:0] peer_window;
	} cmd_t;

endpackage

### rtl/sws_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/sws_front.sv
// ----------------------------------------------------------------------------
// Sender command queue
// Accepts items, classifies the opcode and queues them for the engine.
// ----------------------------------------------------------------------------
module sws_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    opcode,
	input  logic [15:0]   byte_count,
	input  logic [31:0]   ack_sequence,
	input  logic [15:0]   peer_window,
	output logic          cmd_valid,
	input  logic          cmd_take,
	output sws_pkg::cmd_t cmd
);
	localparam int DEPTH = 4;
	localparam int AW = 2;

	sws_pkg::cmd_t wcmd;
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          rd_pend_q;
	logic          cmd_valid_q;
	logic          do_push, do_read;

	always_comb begin
		wcmd.byte_count   = byte_count;
		wcmd.ack_sequence = ack_sequence;
		wcmd.peer_window  = peer_window;
		case (opcode)
			sws_pkg::OP_WRITE: wcmd.op = sws_pkg::OP_WRITE;
			sws_pkg::OP_ACK:   wcmd.op = sws_pkg::OP_ACK;
			sws_pkg::OP_TICK:  wcmd.op = sws_pkg::OP_TICK;
			default:           wcmd.op = sws_pkg::OP_NONE;
		endcase
	end

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign do_push = push && !full;
	// A read is launched when data is stored and the engine has taken the last one.
	// The read address stays on the presented entry until the engine takes it,
	// so the registered read data holds steady while the command waits.
	assign do_read = (cnt_q != '0) && !rd_pend_q && !cmd_valid_q;

	assign cmd_valid = cmd_valid_q;

	sws_ram #(.WIDTH($bits(sws_pkg::cmd_t)), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(do_push), .waddr(wr_q), .wdata(wcmd),
		.raddr(rd_q), .rdata(cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (cmd_take && cmd_valid_q) rd_q <= rd_q + 1'b1;
			rd_pend_q <= do_read;
			if (rd_pend_q) cmd_valid_q <= 1'b1;
			else if (cmd_take) cmd_valid_q <= 1'b0;
			// An entry is freed once the engine takes it.
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(cmd_take && cmd_valid_q);
		end
	end
endmodule

### rtl/sws_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// One result bit per cycle, restoring digit recurrence.
// ----------------------------------------------------------------------------
module sws_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [53:0] value,
	output logic        busy,
	output logic [26:0] root
);
	logic [53:0] rem_q;
	logic [53:0] root_q;
	logic [55:0] bit_q;
	logic        busy_q;
	logic [55:0] trial;

	assign busy  = busy_q;
	assign root  = root_q[26:0];
	assign trial = {2'd0, root_q} + bit_q;

	// root_q holds the running root in the shifted form of the recurrence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
			root_q <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rem_q  <= value;
			root_q <= '0;
			bit_q  <= 56'd1 << 52;
		end else if (busy_q) begin
			if ({2'b0, rem_q} >= trial) begin
				rem_q  <= rem_q - trial[53:0];
				root_q <= 54'({2'd0, root_q >> 1} + bit_q);
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
			if (bit_q == 56'd1) busy_q <= 1'b0;
		end
	end
endmodule

### rtl/sws_engine.sv
// ----------------------------------------------------------------------------
// Sender engine
// Executes writes, acknowledgements and ticks and updates the timeout.
// ----------------------------------------------------------------------------
module sws_engine #(
	parameter int MAX_PAYLOAD = sws_pkg::MAX_PAYLOAD_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [26:0]   cfg_data,
	input  logic          cmd_valid,
	output logic          cmd_take,
	input  sws_pkg::cmd_t cmd,
	output logic          empty,
	input  logic          pop,
	output logic [15:0]   done_count,
	output logic [31:0]   out_sequence,
	output logic          resend_flag,
	output logic [10:0]   resend_length,
	output logic [15:0]   pending_bytes,
	output logic [15:0]   send_credit
);
	localparam logic [15:0] LIM = 16'(MAX_PAYLOAD);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_MSQ, S_VAR, S_START, S_SQRT, S_MUL3, S_DONE
	} state_t;

	state_t      state_q;
	logic [31:0] fu_q, nx_q, we_q, sum_q;
	logic [23:0] age_q;
	logic [53:0] sq_q, var_q;
	logic [5:0]  cnt_q;
	logic [26:0] tmo_q;
	logic [25:0] mean_q;
	logic [51:0] msq_mul_q;
	logic        out_full_q;
	logic        sq_start;
	logic [26:0] root;
	logic        sq_busy;
	logic [15:0] pend, credit, room, acc, rlen;
	logic        inr, dup, tmo_hit;
	logic [23:0] age_inc;
	logic [47:0] age_sq;
	logic [31:0] new_fu;
	logic [47:0] msq_s;
	logic [15:0] res_done, res_pend, res_credit;
	logic [31:0] res_seq;
	logic        res_rflag;
	logic [10:0] res_rlen;

	assign pend   = 16'(nx_q - fu_q);
	assign credit = 16'(we_q - fu_q);
	assign room   = 16'hffff - pend;
	always_comb begin
		acc = cmd.byte_count;
		if (acc > credit) acc = credit;
		if (acc > room) acc = room;
	end
	always_comb begin
		if (fu_q == nx_q) inr = 1'b0;
		else if (fu_q < nx_q) inr = (fu_q < cmd.ack_sequence) && (cmd.ack_sequence <= nx_q);
		else inr = (fu_q < cmd.ack_sequence) || (cmd.ack_sequence <= nx_q);
	end
	assign dup     = (pend != '0) && (cmd.ack_sequence == fu_q);
	assign age_inc = (age_q < sws_pkg::AGE_MAX) ? age_q + 1'b1 : age_q;
	assign tmo_hit = (pend != '0) && ({3'd0, age_inc} > tmo_q);
	assign rlen    = (pend < LIM) ? pend : LIM;
	assign age_sq  = age_q * age_q;
	assign new_fu  = cmd.ack_sequence;
	assign msq_s   = 48'(sq_q >> 6);
	assign empty   = !out_full_q;
	assign sq_start = (state_q == S_START);
	assign cmd_take = (state_q == S_IDLE) && cmd_valid && !out_full_q;

	// Result of the command in execution.
	always_comb begin
		res_done   = '0;
		res_seq    = '0;
		res_rflag  = 1'b0;
		res_rlen   = '0;
		res_pend   = pend;
		res_credit = credit;
		case (cmd.op)
			sws_pkg::OP_WRITE: begin
				res_seq  = nx_q;
				res_done = acc;
				res_pend = pend + acc;
			end
			sws_pkg::OP_ACK: begin
				if (inr) begin
					res_done   = 16'(new_fu - fu_q);
					res_pend   = 16'(nx_q - new_fu);
					res_credit = cmd.peer_window;
				end else if (dup) begin
					res_rflag = 1'b1;
					res_seq   = fu_q;
					res_rlen  = 11'(rlen);
				end
			end
			sws_pkg::OP_TICK: begin
				if (tmo_hit) begin
					res_rflag = 1'b1;
					res_seq   = fu_q;
					res_rlen  = 11'(rlen);
				end
			end
			default: ;
		endcase
	end

	sws_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(var_q),
		.busy(sq_busy), .root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fu_q <= '0;
			nx_q <= '0;
			we_q <= sws_pkg::WINDOW_END_RST;
			age_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			cnt_q <= '0;
			tmo_q <= sws_pkg::TIMEOUT_RST;
			out_full_q <= 1'b0;
			mean_q <= '0;
			msq_mul_q <= '0;
			var_q <= '0;
			done_count <= '0;
			out_sequence <= '0;
			resend_flag <= 1'b0;
			resend_length <= '0;
			pending_bytes <= '0;
			send_credit <= '0;
		end else begin
			if (pop && out_full_q) out_full_q <= 1'b0;
			if (cfg_we) tmo_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) state_q <= S_EXEC;
				end
				S_EXEC: begin
					done_count <= res_done;
					out_sequence <= res_seq;
					resend_flag <= res_rflag;
					resend_length <= res_rlen;
					pending_bytes <= res_pend;
					send_credit <= res_credit;
					// The 64th round-trip sample starts the timeout update.
					state_q <= (cmd.op == sws_pkg::OP_ACK && inr && cnt_q == 6'h3f) ?
						S_MSQ : S_DONE;
					case (cmd.op)
						sws_pkg::OP_WRITE: begin
							if (acc != '0) begin
								if (fu_q == nx_q) age_q <= '0;
								nx_q <= nx_q + 32'(acc);
							end
						end
						sws_pkg::OP_ACK: begin
							if (inr) begin
								fu_q <= new_fu;
								we_q <= new_fu + 32'(cmd.peer_window);
								age_q <= '0;
								sum_q <= sum_q + 32'(age_q);
								sq_q <= sq_q + 54'(age_sq);
								cnt_q <= cnt_q + 1'b1;
							end else if (dup) begin
								age_q <= '0;
							end
						end
						sws_pkg::OP_TICK: begin
							age_q <= tmo_hit ? '0 : age_inc;
						end
						default: ;
					endcase
				end
				S_MSQ: begin
					mean_q <= sum_q[31:6];
					msq_mul_q <= sum_q[31:6] * sum_q[31:6];
					state_q <= S_VAR;
				end
				S_VAR: begin
					var_q <= ({6'd0, msq_s} > {2'd0, msq_mul_q}) ?
						({6'd0, msq_s} - {2'd0, msq_mul_q}) : '0;
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (!sq_busy && !sq_start) state_q <= S_MUL3;
				end
				S_MUL3: begin
					tmo_q <= 27'({1'b0, mean_q} + {root, 1'b0} + root);
					sum_q <= '0;
					sq_q <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_full_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/sliding_window_sender.sv
// ----------------------------------------------------------------------------
// Sliding window sender
// Sequence, window and retransmit timeout tracking for a byte stream.
// ----------------------------------------------------------------------------
// Items enter through a queue interface: push with opcode, byte_count,
// ack_sequence and peer_window is a transfer when full is low. Each item
// gives exactly one result, shown while empty is low and taken with pop.
// A four-entry command queue decouples the input from the engine, which
// handles one item at a time. With the engine idle, a result passes from
// the queue RAM through the read pending and command valid registers and
// the engine's execute and done states, and the engine takes the next
// item only once its result has been popped. The acknowledgement that
// completes 64 round-trip samples also runs the timeout update through
// the one-bit-per-cycle square root unit.
// The engine holds its result register until it is popped, so a stalled
// receiver fills the queue and then raises full. Reset clears all sequence
// state, sets the window end to 0xffff and the timeout to 2000 ms.
// Writing cfg_data with cfg_we loads the timeout directly.
// ----------------------------------------------------------------------------
module sliding_window_sender #(
	parameter int MAX_PAYLOAD = sws_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [26:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [15:0] byte_count,
	input  logic [31:0] ack_sequence,
	input  logic [15:0] peer_window,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] done_count,
	output logic [31:0] out_sequence,
	output logic        resend_flag,
	output logic [10:0] resend_length,
	output logic [15:0] pending_bytes,
	output logic [15:0] send_credit
);
	sws_pkg::cmd_t cmd;
	logic          cmd_valid, cmd_take;

	// Front end: classifies and buffers the transfers.
	sws_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .byte_count(byte_count), .ack_sequence(ack_sequence),
		.peer_window(peer_window), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd)
	);

	// Back end: state update and timeout statistics.
	sws_engine #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_engine (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.empty(empty), .pop(pop), .done_count(done_count),
		.out_sequence(out_sequence), .resend_flag(resend_flag),
		.resend_length(resend_length), .pending_bytes(pending_bytes),
		.send_credit(send_credit)
	);
endmodule

### rtl/sws_checker.sv
// ----------------------------------------------------------------------------
// Sliding window sender checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module sws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        resend_flag,
	input logic [10:0] resend_length,
	input logic [15:0] done_count,
	input logic [31:0] out_sequence
);
	// A waiting result stays shown and keeps its sequence until popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_sequence))
		else $error("result changed while waiting");

	// A resend never reports transferred bytes.
	a_resend_done: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && resend_flag |-> done_count == 16'd0)
		else $error("resend with done count");

	// A resend length is only given with a resend.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !resend_flag |-> resend_length == 11'd0)
		else $error("length without resend");
endmodule

bind sliding_window_sender sws_checker u_sws_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.resend_flag(resend_flag), .resend_length(resend_length),
	.done_count(done_count), .out_sequence(out_sequence)
);

### test/sliding_window_sender_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window sender checker
// Watches the command and result queues, predicts every result of the
// sender and compares the results field by field.
// ----------------------------------------------------------------------------
module sliding_window_sender_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [26:0] cfg_data,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  opcode,
	input  logic [15:0] byte_count,
	input  logic [31:0] ack_sequence,
	input  logic [15:0] peer_window,
	input  logic        empty,
	input  logic        pop,
	input  logic [15:0] done_count,
	input  logic [31:0] out_sequence,
	input  logic        resend_flag,
	input  logic [10:0] resend_length,
	input  logic [15:0] pending_bytes,
	input  logic [15:0] send_credit,
	output int          fail_count,
	output int          waiting,
	output int          result_count,
	output int          resend_count
);
	typedef struct packed {
		logic [15:0] done;
		logic [31:0] seq;
		logic        rflag;
		logic [10:0] rlen;
		logic [15:0] pend;
		logic [15:0] credit;
	} tracker_result_t;

	tracker_result_t expected_results[$];

	logic [31:0] first_unacked, next_to_send, window_end;
	logic [23:0] age;
	logic [31:0] rtt_sum;
	logic [53:0] rtt_sq_sum;
	logic [5:0]  rtt_count;
	logic [26:0] timeout;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root, b;
		root = '0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	task automatic add_round_trip(input logic [23:0] ms);
		logic [63:0] mean, msq, sq, var_est, m;
		m = {40'd0, ms};
		rtt_sum += 32'(ms);
		rtt_sq_sum = rtt_sq_sum + 54'(m * m);
		rtt_count++;
		if (rtt_count == 0) begin
			mean = {32'd0, rtt_sum} >> 6;
			msq = {10'd0, rtt_sq_sum} >> 6;
			sq = mean * mean;
			var_est = (msq > sq) ? msq - sq : '0;
			timeout = 27'(mean + 64'd3 * int_sqrt(var_est));
			rtt_sum = '0;
			rtt_sq_sum = '0;
		end
	endtask

	function automatic logic [15:0] pending_now();
		return 16'(next_to_send - first_unacked);
	endfunction

	task automatic track_item(input sws_pkg::op_t op, input logic [15:0] cnt,
			input logic [31:0] aseq, input logic [15:0] pwin);
		tracker_result_t r;
		logic [15:0] credit, room, acc;
		logic in_range;
		r = '0;
		case (op)
			sws_pkg::OP_WRITE: begin
				credit = 16'(window_end - first_unacked);
				room = 16'hffff - pending_now();
				acc = cnt;
				if (acc > credit) acc = credit;
				if (acc > room) acc = room;
				r.seq = next_to_send;
				if (acc != 0) begin
					if (first_unacked == next_to_send) age = '0;
					next_to_send += 32'(acc);
				end
				r.done = acc;
			end
			sws_pkg::OP_ACK: begin
				if (first_unacked == next_to_send)
					in_range = 1'b0;
				else if (first_unacked < next_to_send)
					in_range = first_unacked < aseq && aseq <= next_to_send;
				else
					in_range = first_unacked < aseq || aseq <= next_to_send;
				if (in_range) begin
					r.done = 16'(aseq - first_unacked);
					add_round_trip(age);
					age = '0;
					first_unacked = aseq;
					window_end = aseq + 32'(pwin);
				end else if (pending_now() != 0 && aseq == first_unacked) begin
					r.rflag = 1'b1;
					r.seq = first_unacked;
					r.rlen = 11'(pending_now() < sws_pkg::MAX_PAYLOAD_DEF ?
						pending_now() : sws_pkg::MAX_PAYLOAD_DEF);
					age = '0;
				end
			end
			sws_pkg::OP_TICK: begin
				if (age < sws_pkg::AGE_MAX) age++;
				if (pending_now() != 0 && {3'd0, age} > timeout) begin
					r.rflag = 1'b1;
					r.seq = first_unacked;
					r.rlen = 11'(pending_now() < sws_pkg::MAX_PAYLOAD_DEF ?
						pending_now() : sws_pkg::MAX_PAYLOAD_DEF);
					age = '0;
				end
			end
			default: ;
		endcase
		r.pend = pending_now();
		r.credit = 16'(window_end - first_unacked);
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		tracker_result_t e;
		if (!arst_n) begin
			first_unacked = '0;
			next_to_send = '0;
			window_end = sws_pkg::WINDOW_END_RST;
			age = '0;
			rtt_sum = '0;
			rtt_sq_sum = '0;
			rtt_count = '0;
			timeout = sws_pkg::TIMEOUT_RST;
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
			resend_count = 0;
		end else begin
			if (cfg_we) timeout = cfg_data;
			if (push && !full)
				track_item(sws_pkg::op_t'(opcode), byte_count, ack_sequence, peer_window);
			if (pop && !empty) begin
				result_count++;
				if (resend_flag) resend_count++;
				if (expected_results.size() == 0) begin
					$error("result transfer with no expected result");
					fail_count++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					if (done_count !== e.done) begin
						$error("done_count: expected %0d, got %0d", e.done, done_count);
						fail_count++;
					end
					if (out_sequence !== e.seq) begin
						$error("out_sequence: expected %0h, got %0h", e.seq, out_sequence);
						fail_count++;
					end
					if (resend_flag !== e.rflag) begin
						$error("resend_flag: expected %0d, got %0d", e.rflag, resend_flag);
						fail_count++;
					end
					if (resend_length !== e.rlen) begin
						$error("resend_length: expected %0d, got %0d", e.rlen,
							resend_length);
						fail_count++;
					end
					if (pending_bytes !== e.pend) begin
						$error("pending_bytes: expected %0d, got %0d", e.pend,
							pending_bytes);
						fail_count++;
					end
					if (send_credit !== e.credit) begin
						$error("send_credit: expected %0d, got %0d", e.credit, send_credit);
						fail_count++;
					end
				end
			end
		end
		// Leftover expectations are failures too; the top reads this at the end.
		waiting = expected_results.size();
	end

endmodule

### test/sliding_window_sender_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window sender testbench
// Drives writes, acknowledgements and ticks through the input queue with
// random bursts and gaps, pops results under a random stall pattern, and
// moves the timeout register between phases; the checker does the scoring.
// ----------------------------------------------------------------------------
module sliding_window_sender_tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [26:0] cfg_data = '0;
	logic        push = 0;
	logic [1:0]  opcode = sws_pkg::OP_TICK;
	logic [15:0] byte_count = '0;
	logic [31:0] ack_sequence = '0;
	logic [15:0] peer_window = '0;
	logic        pop = 0;
	logic        full, empty, resend_flag;
	logic [15:0] done_count, pending_bytes, send_credit;
	logic [31:0] out_sequence;
	logic [10:0] resend_length;
	int          fail_count, waiting, result_count, resend_count;

	// Stimulus keeps its own view of the stream so that most acknowledgements
	// land inside the window of outstanding data.
	logic [31:0] tb_first;
	logic [31:0] tb_next = '0;
	int          burst_left;
	int          items_sent;
	bit          stall_mode = 1'b0;

	always #5 clk = ~clk;

	sliding_window_sender i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .opcode(opcode), .byte_count(byte_count),
		.ack_sequence(ack_sequence), .peer_window(peer_window),
		.empty(empty), .pop(pop), .done_count(done_count),
		.out_sequence(out_sequence), .resend_flag(resend_flag),
		.resend_length(resend_length), .pending_bytes(pending_bytes),
		.send_credit(send_credit)
	);

	sliding_window_sender_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .opcode(opcode), .byte_count(byte_count),
		.ack_sequence(ack_sequence), .peer_window(peer_window),
		.empty(empty), .pop(pop), .done_count(done_count),
		.out_sequence(out_sequence), .resend_flag(resend_flag),
		.resend_length(resend_length), .pending_bytes(pending_bytes),
		.send_credit(send_credit), .fail_count(fail_count), .waiting(waiting),
		.result_count(result_count), .resend_count(resend_count)
	);

	// The receiver alternates between stretches of eager popping and
	// stretches of heavy stalling, changing mode now and then.
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
		pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	// One transfer on the input queue. Gaps come between bursts of random
	// length, and push stays high across back-to-back transfers.
	task automatic send_item(input sws_pkg::op_t op, input logic [15:0] cnt,
			input logic [31:0] aseq, input logic [15:0] pwin);
		if (burst_left == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		push <= 1;
		opcode <= op;
		byte_count <= cnt;
		ack_sequence <= aseq;
		peer_window <= pwin;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
		// The stimulus view only tracks what a write or a good ack may do.
		if (op == sws_pkg::OP_ACK && aseq - tb_first <= tb_next - tb_first) tb_first = aseq;
	endtask

	// Waits out every outstanding result, plus the engine's slow square root.
	task automatic drain();
		push <= 0;
		@(negedge clk);
		while (waiting != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [26:0] t);
		drain();
		cfg_we <= 1;
		cfg_data <= t;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// Writes carry random ack and window fields; the stimulus recovers the
	// accepted count later from the pending byte count in the results.
	task automatic do_write(input logic [15:0] cnt);
		send_item(sws_pkg::OP_WRITE, cnt, $urandom, 16'($urandom));
	endtask

	task automatic do_ack_in_range(input logic [15:0] pwin);
		logic [31:0] span;
		span = tb_next - tb_first;
		if (span == 0) send_item(sws_pkg::OP_ACK, 16'(tb_first), tb_first, pwin);
		else send_item(sws_pkg::OP_ACK, 16'($urandom),
			tb_first + $urandom_range(1, span), pwin);
	endtask

	// Stimulus tracks next_to_send from the results themselves.
	always @(posedge clk)
		if (pop && !empty && opcode !== 2'bx) begin
			if (pending_bytes != 0 || done_count != 0)
				tb_next = tb_first + 32'(pending_bytes);
		end

	initial begin
		int k;
		tb_first = '0;
		burst_left = 0;
		items_sent = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: ack and tick with nothing pending, unknown opcode, writes
		// of nothing and of the full field width, which is the whole window.
		send_item(sws_pkg::OP_ACK, '0, 32'hffff_ffff, 16'hffff);
		send_item(sws_pkg::OP_TICK, 16'hffff, '0, '0);
		send_item(sws_pkg::OP_NONE, 16'hffff, 32'hffff_ffff, 16'hffff);
		do_write('0);
		do_write(16'hffff);
		drain();
		// Duplicate ack resends the oldest data; out of range ack is ignored.
		send_item(sws_pkg::OP_ACK, '0, tb_first, 16'h1234);
		send_item(sws_pkg::OP_ACK, '0, tb_first - 32'd1, '0);
		do_ack_in_range(16'hffff);
		drain();
		do_ack_in_range('0);
		drain();
		do_write(16'd100);
		// Zero peer window leaves no credit; the write takes nothing.
		drain();
		do_ack_in_range(16'h8000);
		drain();
		do_write(16'h8000);
		drain();
		// Zero timeout resends on every tick with data pending.
		set_timeout('0);
		repeat (4) send_item(sws_pkg::OP_TICK, '0, '0, '0);
		set_timeout(27'h7ff_ffff);
		repeat (3) send_item(sws_pkg::OP_TICK, '0, '0, '0);
		set_timeout(27'd3);
		repeat (6) send_item(sws_pkg::OP_TICK, '0, '0, '0);

		// Random part: mostly write / tick / in-range ack, some noise.
		// Phases change the timeout; in-range acks from all phases feed the
		// 64-sample statistics update.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_timeout(27'd1);
				1: set_timeout(27'($urandom_range(2, 40)));
				2: set_timeout(27'h7ff_ffff);
				default: set_timeout(27'd2000);
			endcase
			for (k = 0; k < 100; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: do_write($urandom_range(0, 3) == 0 ?
						16'($urandom) : 16'($urandom_range(0, 2048)));
					3, 4: do_ack_in_range($urandom_range(0, 1) ? 16'hffff :
						16'($urandom));
					5, 6: send_item(sws_pkg::OP_TICK, 16'($urandom), $urandom,
						16'($urandom));
					7: send_item(sws_pkg::OP_ACK, 16'($urandom), tb_first,
						16'($urandom));
					8: send_item(sws_pkg::OP_ACK, 16'($urandom), $urandom,
						16'($urandom));
					default: send_item(sws_pkg::op_t'($urandom_range(0, 3)),
						16'($urandom), $urandom, 16'($urandom));
				endcase
				// Let the stimulus view catch up with the results now and then.
				if (k % 25 == 24) drain();
			end
		end
		drain();

		$display("Covered %0d input transfers and %0d results, %0d of them resends,",
			items_sent, result_count, resend_count);
		$display("across zero, small, default and maximum retransmit timeouts.");
		if (fail_count == 0 && waiting == 0) begin
			$display("[sliding_window_sender] OK");
		end else begin
			$display("[sliding_window_sender] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("[sliding_window_sender] ERROR");
		$finish;
	end

endmodule
